>>> hdl/fwbc_pkg.sv
// Shared types, codes, field layout and the control-store contents of the block cache controller.
// No dependencies; imported by every module of the block.
package fwbc_pkg;

    localparam int SLOTS       = 16;
    localparam int BLOCK_BYTES = 4096;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int OFF_W   = $clog2(BLOCK_BYTES);

    localparam int OP_W    = 2;
    localparam int FID_W   = 10;
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 13;
    localparam int KIND_W  = 2;
    localparam int SLOTF_W = 4;
    localparam int CAP_W   = 5;

    // beat layouts
    localparam int IN_FID_LSB  = 0;
    localparam int IN_ADDR_LSB = IN_FID_LSB + FID_W;
    localparam int IN_WLEN_LSB = IN_ADDR_LSB + ADDR_W;
    localparam int IN_USED_W   = IN_WLEN_LSB + LEN_W;
    localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

    localparam int OUT_FID_LSB  = 0;
    localparam int OUT_ADDR_LSB = OUT_FID_LSB + FID_W;
    localparam int OUT_LEN_LSB  = OUT_ADDR_LSB + ADDR_W;
    localparam int OUT_SLOT_LSB = OUT_LEN_LSB + LEN_W;
    localparam int OUT_HIT_BIT  = OUT_SLOT_LSB + SLOTF_W;
    localparam int OUT_SAT_BIT  = OUT_HIT_BIT + 1;
    localparam int OUT_USED_W   = OUT_SAT_BIT + 1;
    localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_USED_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(SLOTS);

    // operations
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_SYNC  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_WB        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FETCH     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SYNC_DONE = 2'd3;

    // sequencer steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] ST_IDLE      = 3'd0;
    localparam logic [STEP_W-1:0] ST_LOOKUP    = 3'd1;
    localparam logic [STEP_W-1:0] ST_CHECK     = 3'd2;
    localparam logic [STEP_W-1:0] ST_EVICT     = 3'd3;
    localparam logic [STEP_W-1:0] ST_ALLOC     = 3'd4;
    localparam logic [STEP_W-1:0] ST_DONE      = 3'd5;
    localparam logic [STEP_W-1:0] ST_SYNC      = 3'd6;
    localparam logic [STEP_W-1:0] ST_SYNC_DONE = 3'd7;

    // datapath actions
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LATCH  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd2;
    localparam logic [ACT_W-1:0] ACT_EVICT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SYNC   = 3'd6;

    // emit qualifiers
    localparam int EM_W = 2;
    localparam logic [EM_W-1:0] EM_NONE   = 2'd0;
    localparam logic [EM_W-1:0] EM_ALWAYS = 2'd1;
    localparam logic [EM_W-1:0] EM_VICTIM = 2'd2;
    localparam logic [EM_W-1:0] EM_SYNC   = 2'd3;

    // jump conditions; not taken means step + 1
    localparam int JC_W = 3;
    localparam logic [JC_W-1:0] JC_NEXT     = 3'd0;
    localparam logic [JC_W-1:0] JC_ALWAYS   = 3'd1;
    localparam logic [JC_W-1:0] JC_SYNC     = 3'd2;
    localparam logic [JC_W-1:0] JC_HIT      = 3'd3;
    localparam logic [JC_W-1:0] JC_NO_EVICT = 3'd4;
    localparam logic [JC_W-1:0] JC_MORE     = 3'd5;

    typedef struct packed {
        logic              need_cmd;
        logic [ACT_W-1:0]  act;
        logic [EM_W-1:0]   emit;
        logic [KIND_W-1:0] kind;
        logic [JC_W-1:0]   jc;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic              take;
        logic              go;
        logic [ACT_W-1:0]  act;
        logic              emit;
        logic [KIND_W-1:0] kind;
    } ctl_t;

    typedef struct packed {
        logic hit;
        logic need_evict;
        logic cur_dirty;
        logic cur_len_nz;
        logic cur_last;
    } slot_stat_t;

    typedef struct packed {
        logic       cmd_ok;
        logic       is_sync;
        logic       out_free;
        slot_stat_t slot;
    } stat_t;

    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '0;
        case (step)
            ST_IDLE:
            begin
                w.need_cmd = 1'b1;
                w.act      = ACT_LATCH;
                w.jc       = JC_SYNC;
                w.target   = ST_SYNC;
            end
            ST_LOOKUP:
            begin
                w.act    = ACT_LOOKUP;
                w.jc     = JC_HIT;
                w.target = ST_DONE;
            end
            ST_CHECK:
            begin
                w.jc     = JC_NO_EVICT;
                w.target = ST_ALLOC;
            end
            ST_EVICT:
            begin
                w.act  = ACT_EVICT;
                w.emit = EM_VICTIM;
                w.kind = KIND_WB;
            end
            ST_ALLOC:
            begin
                w.act  = ACT_ALLOC;
                w.emit = EM_ALWAYS;
                w.kind = KIND_FETCH;
            end
            ST_DONE:
            begin
                w.act    = ACT_UPDATE;
                w.emit   = EM_ALWAYS;
                w.kind   = KIND_DONE;
                w.jc     = JC_ALWAYS;
                w.target = ST_IDLE;
            end
            ST_SYNC:
            begin
                w.act    = ACT_SYNC;
                w.emit   = EM_SYNC;
                w.kind   = KIND_WB;
                w.jc     = JC_MORE;
                w.target = ST_SYNC;
            end
            ST_SYNC_DONE:
            begin
                w.emit   = EM_ALWAYS;
                w.kind   = KIND_SYNC_DONE;
                w.jc     = JC_ALWAYS;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.jc     = JC_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hdl/fwbc_sequencer.sv
// Step counter and control-store fetch; resolves stalls, emit qualifiers and jumps.
// Depends on fwbc_pkg (microword layout and program).
module fwbc_sequencer
    import fwbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctl_t  ctl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    uword_t            uw;
    logic              emit_now;
    logic              stall;
    logic              jump;

    assign uw = ucode(step_reg);

    always_comb
    begin
        case (uw.emit)
            EM_ALWAYS: emit_now = 1'b1;
            EM_VICTIM: emit_now = stat.slot.cur_dirty;
            EM_SYNC:   emit_now = stat.slot.cur_dirty && stat.slot.cur_len_nz;
            default:   emit_now = 1'b0;
        endcase

        // hold the step while waiting for a command or for room in the output register
        stall = (uw.need_cmd && !stat.cmd_ok) || (emit_now && !stat.out_free);

        case (uw.jc)
            JC_ALWAYS:   jump = 1'b1;
            JC_SYNC:     jump = stat.is_sync;
            JC_HIT:      jump = stat.slot.hit;
            JC_NO_EVICT: jump = !stat.slot.need_evict;
            JC_MORE:     jump = !stat.slot.cur_last;
            default:     jump = 1'b0;
        endcase

        step_next = step_reg;
        if (!stall)
        begin
            step_next = jump ? uw.target : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign ctl.take = uw.need_cmd;
    assign ctl.go   = !stall;
    assign ctl.act  = uw.act;
    assign ctl.emit = emit_now && !stall;
    assign ctl.kind = uw.kind;

endmodule

>>> hdl/fwbc_slot_store.sv
// Slot state of the cache: valid/dirty bits, tags, file handles, valid lengths, FIFO ring.
// Depends on fwbc_pkg; driven by the control word from fwbc_sequencer.
module fwbc_slot_store
    import fwbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl,
    input  logic [CAP_W-1:0]  cap,
    input  logic [ADDR_W-1:0] base,
    input  logic [FID_W-1:0]  fid,
    input  logic              wr,
    input  logic [OFF_W-1:0]  offset,
    input  logic [LEN_W-1:0]  wlen,
    output slot_stat_t        sstat,
    output logic [SLOT_W-1:0] cur,
    output logic [SLOT_W-1:0] alloc_slot,
    output logic [FID_W-1:0]  cur_file,
    output logic [ADDR_W-1:0] cur_tag,
    output logic [LEN_W-1:0]  cur_len,
    output logic [LEN_W-1:0]  new_len,
    output logic              sat,
    output logic              hit_q
);

    logic [SLOTS-1:0]  valid_reg;
    logic [SLOTS-1:0]  dirty_reg;
    logic [ADDR_W-1:0] tag_reg  [SLOTS];
    logic [FID_W-1:0]  file_reg [SLOTS];
    logic [LEN_W-1:0]  len_reg  [SLOTS];
    logic [SLOT_W-1:0] oldest_reg;
    logic [CNT_W-1:0]  filled_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic              hit_q_reg;

    logic              hit_any;
    logic [SLOT_W-1:0] hit_idx;
    logic [CNT_W-1:0]  cap_eff;
    logic [CNT_W:0]    ring_sum;
    logic [SLOT_W-1:0] oldest_inc;
    logic [LEN_W:0]    end_sum;
    logic              end_over;
    logic [LEN_W-1:0]  end_clip;

    // parallel tag compare, lowest matching slot wins
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && tag_reg[i] == base)
            begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        if (cap == '0)
            cap_eff = CNT_W'(1);
        else if (32'(cap) > SLOTS)
            cap_eff = CNT_W'(SLOTS);
        else
            cap_eff = CNT_W'(cap);
    end

    // next free slot is the one after the youngest
    assign ring_sum   = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(filled_reg);
    assign alloc_slot = (32'(ring_sum) >= SLOTS) ? SLOT_W'(32'(ring_sum) - SLOTS)
                                                 : SLOT_W'(ring_sum);
    assign oldest_inc = (oldest_reg == SLOT_W'(SLOTS - 1)) ? '0 : oldest_reg + 1'b1;

    assign cur      = cur_reg;
    assign cur_file = file_reg[cur_reg];
    assign cur_tag  = tag_reg[cur_reg];
    assign cur_len  = len_reg[cur_reg];
    assign hit_q    = hit_q_reg;

    // write end, clipped at the block end
    assign end_sum  = (LEN_W + 1)'(offset) + (LEN_W + 1)'(wlen);
    assign end_over = end_sum > (LEN_W + 1)'(BLOCK_BYTES);
    assign end_clip = end_over ? LEN_W'(BLOCK_BYTES) : LEN_W'(end_sum);
    assign new_len  = (wr && end_clip > cur_len) ? end_clip : cur_len;
    assign sat      = wr && end_over;

    assign sstat.hit        = hit_any;
    assign sstat.need_evict = filled_reg >= cap_eff;
    assign sstat.cur_dirty  = valid_reg[cur_reg] && dirty_reg[cur_reg];
    assign sstat.cur_len_nz = cur_len != '0;
    assign sstat.cur_last   = cur_reg == SLOT_W'(SLOTS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            dirty_reg  <= '0;
            oldest_reg <= '0;
            filled_reg <= '0;
            cur_reg    <= '0;
            hit_q_reg  <= 1'b0;
        end
        else if (ctl.go)
        begin
            case (ctl.act)
                ACT_LATCH:
                begin
                    cur_reg <= '0;
                end
                ACT_LOOKUP:
                begin
                    hit_q_reg <= hit_any;
                    cur_reg   <= hit_any ? hit_idx : oldest_reg;
                end
                ACT_EVICT:
                begin
                    valid_reg[cur_reg] <= 1'b0;
                    dirty_reg[cur_reg] <= 1'b0;
                    oldest_reg         <= oldest_inc;
                    filled_reg         <= filled_reg - 1'b1;
                end
                ACT_ALLOC:
                begin
                    valid_reg[alloc_slot] <= 1'b1;
                    dirty_reg[alloc_slot] <= 1'b0;
                    filled_reg            <= filled_reg + 1'b1;
                    cur_reg               <= alloc_slot;
                end
                ACT_UPDATE:
                begin
                    if (wr)
                    begin
                        dirty_reg[cur_reg] <= 1'b1;
                    end
                end
                ACT_SYNC:
                begin
                    dirty_reg[cur_reg] <= 1'b0;
                    cur_reg            <= cur_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.go && ctl.act == ACT_ALLOC)
        begin
            tag_reg[alloc_slot]  <= base;
            file_reg[alloc_slot] <= fid;
            len_reg[alloc_slot]  <= '0;
        end
        else if (ctl.go && ctl.act == ACT_UPDATE)
        begin
            len_reg[cur_reg] <= new_len;
        end
    end

endmodule

>>> hdl/fifo_write_back_block_cache.sv
// Top level of the FIFO write-back block cache controller: command latch, output register,
// capacity register. Depends on fwbc_pkg, fwbc_sequencer and fwbc_slot_store.
//
//   channel  dir  signals                                 beat
//   s_*      in   tvalid/tready, tuser=op, tdata          one access or sync command
//   m_*      out  tvalid/tready, tuser=kind, tdata, tlast writeback, fetch or done result
//   cfg_*    in   wr_en, wr_data                          capacity limit, no handshake
//
// A command is taken in the idle step; a hit access then runs lookup and done, a miss
// lookup, check, an eviction step when full, fetch and done; sync takes one step per slot.
// Every result beat goes through one output register; a step that emits waits while
// that register is still full and not being taken.
// Reset clears valid and dirty bits, ring pointer and fill count, and sets the limit to 16.
module fifo_write_back_block_cache
    import fwbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // file_id, byte_address, write_length, pad
    input  logic [OP_W-1:0]       s_tuser,   // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // file_id_out, block_address, length, slot, hit,
                                             // saturated, pad
    output logic [KIND_W-1:0]     m_tuser,   // kind
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CAP_W-1:0]      cfg_wr_data
);

    logic [CAP_W-1:0]      cap_reg;
    logic [OP_W-1:0]       op_reg;
    logic [FID_W-1:0]      fid_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [LEN_W-1:0]      wlen_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [KIND_W-1:0]     out_kind_reg;
    logic                  out_last_reg;

    ctl_t                  ctl;
    stat_t                 stat;
    slot_stat_t            sstat;
    logic [ADDR_W-1:0]     base;
    logic [SLOT_W-1:0]     cur;
    logic [SLOT_W-1:0]     alloc_slot;
    logic [FID_W-1:0]      cur_file;
    logic [ADDR_W-1:0]     cur_tag;
    logic [LEN_W-1:0]      cur_len;
    logic [LEN_W-1:0]      new_len;
    logic                  sat;
    logic                  hit_q;

    logic [FID_W-1:0]      e_fid;
    logic [ADDR_W-1:0]     e_addr;
    logic [LEN_W-1:0]      e_len;
    logic [SLOTF_W-1:0]    e_slot;
    logic                  e_hit;
    logic                  e_sat;
    logic                  e_last;

    assign base = {addr_reg[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};

    assign stat.cmd_ok   = s_tvalid && s_tuser != OP_NONE;
    assign stat.is_sync  = s_tuser == OP_SYNC;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.slot     = sstat;

    fwbc_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    fwbc_slot_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cap        (cap_reg),
        .base       (base),
        .fid        (fid_reg),
        .wr         (op_reg == OP_WRITE),
        .offset     (addr_reg[OFF_W-1:0]),
        .wlen       (wlen_reg),
        .sstat      (sstat),
        .cur        (cur),
        .alloc_slot (alloc_slot),
        .cur_file   (cur_file),
        .cur_tag    (cur_tag),
        .cur_len    (cur_len),
        .new_len    (new_len),
        .sat        (sat),
        .hit_q      (hit_q)
    );

    // ready in the command step; an unused op is taken and dropped there
    assign s_tready = ctl.take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.go && ctl.act == ACT_LATCH)
        begin
            op_reg   <= s_tuser;
            fid_reg  <= s_tdata[IN_FID_LSB +: FID_W];
            addr_reg <= s_tdata[IN_ADDR_LSB +: ADDR_W];
            wlen_reg <= s_tdata[IN_WLEN_LSB +: LEN_W];
        end
    end

    always_comb
    begin
        e_fid  = '0;
        e_addr = '0;
        e_len  = '0;
        e_slot = '0;
        e_hit  = 1'b0;
        e_sat  = 1'b0;
        e_last = 1'b0;
        case (ctl.kind)
            KIND_WB:
            begin
                e_fid  = cur_file;
                e_addr = cur_tag;
                // eviction writes the whole block, sync only the valid part
                e_len  = (op_reg == OP_SYNC) ? cur_len : LEN_W'(BLOCK_BYTES);
                e_slot = SLOTF_W'(cur);
            end
            KIND_FETCH:
            begin
                e_fid  = fid_reg;
                e_addr = base;
                e_slot = SLOTF_W'(alloc_slot);
            end
            KIND_DONE:
            begin
                e_fid  = cur_file;
                e_addr = base;
                e_len  = new_len;
                e_slot = SLOTF_W'(cur);
                e_hit  = hit_q;
                e_sat  = sat;
                e_last = 1'b1;
            end
            KIND_SYNC_DONE:
            begin
                e_last = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, e_sat, e_hit, e_slot, e_len, e_addr, e_fid};
            out_kind_reg <= ctl.kind;
            out_last_reg <= e_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> hdl/fwbc_checker.sv
// Port-level checks for fifo_write_back_block_cache, attached by the bind at the end.
// Depends on fwbc_pkg for field positions and codes.
module fwbc_checker
    import fwbc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [OP_W-1:0]       s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]     m_tuser,
    input logic                  m_tlast
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // only done results close an item
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_DONE || m_tuser == KIND_SYNC_DONE)))
        else $error("tlast does not match result kind");

    a_fetch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_FETCH |-> m_tdata[OUT_LEN_LSB +: LEN_W] == '0
            && !m_tdata[OUT_HIT_BIT] && !m_tdata[OUT_SAT_BIT])
        else $error("fetch beat carries length or flags");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_WB)
            |-> m_tdata[OUT_LEN_LSB +: LEN_W] <= LEN_W'(BLOCK_BYTES))
        else $error("length beyond block size");

    // a sync walk keeps the input closed on the next cycle
    a_sync_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == OP_SYNC |=> !s_tready)
        else $error("command taken during sync walk");

endmodule

bind fifo_write_back_block_cache fwbc_checker u_fwbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
